/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the I2C sequencer RTL. They are compiled away
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked at every rising edge of clk while out of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true at a rising edge of clk out of reset.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)

`endif

`endif

/* hdl/i2cms_pkg.sv */
// ----------------------------------------------------------------------------
// i2cms_pkg
// Types and codes shared by the I2C master write-read sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  // Commands issued to the bus-controller core.
  localparam logic [2:0] CMD_NONE    = 3'd0;
  localparam logic [2:0] CMD_START   = 3'd1;
  localparam logic [2:0] CMD_SEND    = 3'd2;
  localparam logic [2:0] CMD_RSTART  = 3'd3;
  localparam logic [2:0] CMD_STOP    = 3'd4;
  localparam logic [2:0] CMD_RXDUMMY = 3'd5;
  localparam logic [2:0] CMD_READ    = 3'd6;

  // Item kinds carried by the mode field.
  localparam logic MODE_REQUEST = 1'b0;
  localparam logic MODE_EVENT   = 1'b1;

  // Sequencer phases.
  localparam logic [3:0] PH_IDLE        = 4'd0;
  localparam logic [3:0] PH_WAIT_START  = 4'd1;
  localparam logic [3:0] PH_WAIT_ADDR   = 4'd2;
  localparam logic [3:0] PH_WAIT_WRITE  = 4'd3;
  localparam logic [3:0] PH_WAIT_RSTART = 4'd4;
  localparam logic [3:0] PH_WAIT_RADDR  = 4'd5;
  localparam logic [3:0] PH_WAIT_STOPW  = 4'd6;
  localparam logic [3:0] PH_WAIT_DUMMY  = 4'd7;
  localparam logic [3:0] PH_WAIT_READ   = 4'd8;
  localparam logic [3:0] PH_WAIT_STOPR  = 4'd9;

  // Classified interrupt events.
  localparam logic [2:0] EV_START   = 3'd0;
  localparam logic [2:0] EV_STOP    = 3'd1;
  localparam logic [2:0] EV_ADDR    = 3'd2;
  localparam logic [2:0] EV_ARBL    = 3'd3;
  localparam logic [2:0] EV_DONE    = 3'd4;
  localparam logic [2:0] EV_UNKNOWN = 3'd5;

  typedef struct packed {
    logic       mode;
    logic [6:0] target_address;
    logic [7:0] write_count;
    logic [7:0] read_count;
    logic       start_flag;
    logic       stop_flag;
    logic       addressed_flag;
    logic       arbitration_lost_flag;
    logic       transfer_done_flag;
    logic       nack_received;
    logic [7:0] next_write_byte;
    logic [7:0] read_byte;
  } item_t;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] bus_byte;
    logic       nack_next;
    logic [7:0] received_byte;
    logic       received_valid;
    logic       finished;
    logic       success;
  } result_t;

endpackage

/* hdl/i2cms_core.sv */
// ----------------------------------------------------------------------------
// i2cms_core
// Transaction state and the single-pass step logic: classifies an item,
// produces its result and updates the state when the item is taken.
// ----------------------------------------------------------------------------
module i2cms_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  i2cms_pkg::item_t  item,
  output i2cms_pkg::result_t result
);

  logic [3:0] phase_r, phase_nxt;
  logic [7:0] byte_index_r, byte_index_nxt;
  logic [7:0] write_total_r, write_total_nxt;
  logic [7:0] read_total_r, read_total_nxt;
  logic [6:0] peer_address_r, peer_address_nxt;

  logic [2:0] ev;
  logic       fail;
  logic [7:0] rd_idx;
  logic [8:0] rd_idx_p1;
  logic [8:0] rd_idx_p2;
  i2cms_pkg::result_t res;

  always_comb begin
    if (item.start_flag) begin
      ev = i2cms_pkg::EV_START;
    end else if (item.stop_flag) begin
      ev = i2cms_pkg::EV_STOP;
    end else if (item.addressed_flag) begin
      ev = i2cms_pkg::EV_ADDR;
    end else if (item.arbitration_lost_flag) begin
      ev = i2cms_pkg::EV_ARBL;
    end else if (item.transfer_done_flag) begin
      ev = i2cms_pkg::EV_DONE;
    end else begin
      ev = i2cms_pkg::EV_UNKNOWN;
    end
  end

  // The receive loop restarts its index when leaving the dummy read.
  assign rd_idx    = (phase_r == i2cms_pkg::PH_WAIT_DUMMY) ? 8'd0 : byte_index_r;
  assign rd_idx_p1 = {1'b0, rd_idx} + 9'd1;
  assign rd_idx_p2 = {1'b0, rd_idx} + 9'd2;

  always_comb begin
    phase_nxt        = phase_r;
    byte_index_nxt   = byte_index_r;
    write_total_nxt  = write_total_r;
    read_total_nxt   = read_total_r;
    peer_address_nxt = peer_address_r;
    res              = '0;
    fail             = 1'b0;

    if (item.mode == i2cms_pkg::MODE_REQUEST) begin
      if (phase_r == i2cms_pkg::PH_IDLE) begin
        peer_address_nxt = item.target_address;
        write_total_nxt  = item.write_count;
        read_total_nxt   = item.read_count;
        byte_index_nxt   = 8'd0;
        if (item.write_count == 8'd0 && item.read_count == 8'd0) begin
          res.finished = 1'b1;
        end else begin
          res.command = i2cms_pkg::CMD_START;
          phase_nxt   = i2cms_pkg::PH_WAIT_START;
        end
      end
    end else if (phase_r != i2cms_pkg::PH_IDLE) begin
      case (phase_r)
        i2cms_pkg::PH_WAIT_START: begin
          if (ev != i2cms_pkg::EV_START) begin
            fail = 1'b1;
          end else begin
            res.command  = i2cms_pkg::CMD_SEND;
            res.bus_byte = {peer_address_r, (write_total_r == 8'd0)};
            phase_nxt    = i2cms_pkg::PH_WAIT_ADDR;
          end
        end
        i2cms_pkg::PH_WAIT_ADDR: begin
          if (ev != i2cms_pkg::EV_DONE) begin
            fail = 1'b1;
          end else if (write_total_r != 8'd0) begin
            byte_index_nxt = 8'd0;
            if (item.nack_received) begin
              fail = 1'b1;
            end else begin
              res.command    = i2cms_pkg::CMD_SEND;
              res.bus_byte   = item.next_write_byte;
              byte_index_nxt = 8'd1;
              phase_nxt      = i2cms_pkg::PH_WAIT_WRITE;
            end
          end else begin
            res.command   = i2cms_pkg::CMD_RXDUMMY;
            res.nack_next = (read_total_r == 8'd1);
            phase_nxt     = i2cms_pkg::PH_WAIT_DUMMY;
          end
        end
        i2cms_pkg::PH_WAIT_WRITE: begin
          if (ev != i2cms_pkg::EV_DONE) begin
            fail = 1'b1;
          end else if (byte_index_r < write_total_r) begin
            if (item.nack_received) begin
              fail = 1'b1;
            end else begin
              res.command    = i2cms_pkg::CMD_SEND;
              res.bus_byte   = item.next_write_byte;
              byte_index_nxt = byte_index_r + 8'd1;
              phase_nxt      = i2cms_pkg::PH_WAIT_WRITE;
            end
          end else if (read_total_r != 8'd0) begin
            res.command = i2cms_pkg::CMD_RSTART;
            phase_nxt   = i2cms_pkg::PH_WAIT_RSTART;
          end else begin
            res.command = i2cms_pkg::CMD_STOP;
            phase_nxt   = i2cms_pkg::PH_WAIT_STOPW;
          end
        end
        i2cms_pkg::PH_WAIT_RSTART: begin
          if (ev != i2cms_pkg::EV_START) begin
            fail = 1'b1;
          end else begin
            res.command  = i2cms_pkg::CMD_SEND;
            res.bus_byte = {peer_address_r, 1'b1};
            phase_nxt    = i2cms_pkg::PH_WAIT_RADDR;
          end
        end
        i2cms_pkg::PH_WAIT_RADDR: begin
          if (ev != i2cms_pkg::EV_DONE) begin
            fail = 1'b1;
          end else begin
            res.command   = i2cms_pkg::CMD_RXDUMMY;
            res.nack_next = (read_total_r == 8'd1);
            phase_nxt     = i2cms_pkg::PH_WAIT_DUMMY;
          end
        end
        i2cms_pkg::PH_WAIT_STOPW: begin
          if (ev != i2cms_pkg::EV_STOP) begin
            fail = 1'b1;
          end else begin
            res.finished = 1'b1;
            res.success  = 1'b1;
            phase_nxt    = i2cms_pkg::PH_IDLE;
          end
        end
        i2cms_pkg::PH_WAIT_DUMMY, i2cms_pkg::PH_WAIT_READ: begin
          if (ev != i2cms_pkg::EV_DONE) begin
            fail = 1'b1;
          end else begin
            byte_index_nxt = rd_idx;
            res.nack_next  = (rd_idx_p2 == {1'b0, read_total_r});
            if (rd_idx_p1 == {1'b0, read_total_r}) begin
              // Last byte: stop first, the byte is taken on the stop event.
              res.command = i2cms_pkg::CMD_STOP;
              phase_nxt   = i2cms_pkg::PH_WAIT_STOPR;
            end else begin
              res.command        = i2cms_pkg::CMD_READ;
              res.received_byte  = item.read_byte;
              res.received_valid = 1'b1;
              byte_index_nxt     = rd_idx_p1[7:0];
              phase_nxt          = i2cms_pkg::PH_WAIT_READ;
            end
          end
        end
        i2cms_pkg::PH_WAIT_STOPR: begin
          if (ev != i2cms_pkg::EV_STOP) begin
            fail = 1'b1;
          end else begin
            res.command        = i2cms_pkg::CMD_READ;
            res.received_byte  = item.read_byte;
            res.received_valid = 1'b1;
            res.finished       = 1'b1;
            res.success        = 1'b1;
            phase_nxt          = i2cms_pkg::PH_IDLE;
          end
        end
        default: begin
          phase_nxt = i2cms_pkg::PH_IDLE;
        end
      endcase

      if (fail) begin
        res          = '0;
        res.finished = 1'b1;
        phase_nxt    = i2cms_pkg::PH_IDLE;
      end
    end
  end

  assign result = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= i2cms_pkg::PH_IDLE;
      byte_index_r   <= 8'd0;
      write_total_r  <= 8'd0;
      read_total_r   <= 8'd0;
      peer_address_r <= 7'd0;
    end else if (fire) begin
      phase_r        <= phase_nxt;
      byte_index_r   <= byte_index_nxt;
      write_total_r  <= write_total_nxt;
      read_total_r   <= read_total_nxt;
      peer_address_r <= peer_address_nxt;
    end
  end

endmodule

/* hdl/i2c_master_write_read_sequencer.sv */
// An item is captured in the input register when transferred in; its result is
// then captured in the result register. Throughput: one item per cycle while
// out_stall is low. The input register takes one more item behind a waiting
// result; the input stalls only when both registers are full and out_stall is set.
// Reset: synchronous, active low; clears both valid flags and returns the
// sequencer to idle with all counters and the address cleared.
// ----------------------------------------------------------------------------
// i2c_master_write_read_sequencer
// Sequences one I2C master transaction (start, address, writes, repeated
// start, reads, stop) over a bus-controller core, at most one command per event.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2c_master_write_read_sequencer (
  input  logic       clk,
  input  logic       rst_n,

  // Request and interrupt-event channel.
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_mode,
  input  logic [6:0] in_target_address,
  input  logic [7:0] in_write_count,
  input  logic [7:0] in_read_count,
  input  logic       in_start_flag,
  input  logic       in_stop_flag,
  input  logic       in_addressed_flag,
  input  logic       in_arbitration_lost_flag,
  input  logic       in_transfer_done_flag,
  input  logic       in_nack_received,
  input  logic [7:0] in_next_write_byte,
  input  logic [7:0] in_read_byte,

  // Command and status channel.
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_command,
  output logic [7:0] out_bus_byte,
  output logic       out_nack_next,
  output logic [7:0] out_received_byte,
  output logic       out_received_valid,
  output logic       out_finished,
  output logic       out_success
);

  // Input register: holds one transferred item until the step logic takes it.
  logic               in_v_r;
  i2cms_pkg::item_t   item_r;
  i2cms_pkg::item_t   item_nxt;

  // Result register: holds one finished result until the consumer takes it.
  logic               out_v_r;
  i2cms_pkg::result_t res_r;
  i2cms_pkg::result_t step_res;

  // The step fires when an item waits and the result register is free or
  // is being emptied in this same cycle.
  logic advance;

  assign advance  = in_v_r && (!out_v_r || !out_stall);
  // The input register only blocks when it is full and cannot move on.
  assign in_stall = in_v_r && !advance;

  always_comb begin
    item_nxt.mode                  = in_mode;
    item_nxt.target_address        = in_target_address;
    item_nxt.write_count           = in_write_count;
    item_nxt.read_count            = in_read_count;
    item_nxt.start_flag            = in_start_flag;
    item_nxt.stop_flag             = in_stop_flag;
    item_nxt.addressed_flag        = in_addressed_flag;
    item_nxt.arbitration_lost_flag = in_arbitration_lost_flag;
    item_nxt.transfer_done_flag    = in_transfer_done_flag;
    item_nxt.nack_received         = in_nack_received;
    item_nxt.next_write_byte       = in_next_write_byte;
    item_nxt.read_byte             = in_read_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= item_nxt;
    end
  end

  // Transaction state and step logic; the state moves only when an item
  // is actually consumed, so a stalled item is evaluated again unchanged.
  i2cms_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .item   (item_r),
    .result (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= step_res;
    end
  end

  assign out_valid          = out_v_r;
  assign out_command        = res_r.command;
  assign out_bus_byte       = res_r.bus_byte;
  assign out_nack_next      = res_r.nack_next;
  assign out_received_byte  = res_r.received_byte;
  assign out_received_valid = res_r.received_valid;
  assign out_finished       = res_r.finished;
  assign out_success        = res_r.success;

  // A consumed item always leaves a result in the result register.
  `ASSERT_CLK(a_adv_fills_out, advance |=> out_v_r, "step fired but no result registered")
  // The input side only stalls behind a full, stalled result register.
  `ASSERT_CLK(a_stall_cause, in_stall |-> (out_v_r && out_stall), "input stalled without cause")
  // A delivered byte always travels with a read command.
  `ASSERT_CLK(a_rx_cmd, (out_v_r && res_r.received_valid) |-> (res_r.command == i2cms_pkg::CMD_READ), "received byte without read command")
  // Success is only reported when the transaction ends.
  `ASSERT_NEVER(a_success_fin, out_v_r && res_r.success && !res_r.finished, "success without finished")

endmodule
